[rtl/core/tws_pkg.sv]
// shared types, constants and helper functions of the texture wrap sampler
package tws_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int COLOR_BITS  = 24;

    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 24;
    localparam int FRAC_W      = 16;
    localparam int INDEX_W     = 12;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // a size register can not exceed its 7-bit field
    localparam int W_LIMIT     = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
    localparam int H_LIMIT     = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int XW          = (W_LIMIT > 1) ? $clog2(W_LIMIT) : 1;
    localparam int YW          = (H_LIMIT > 1) ? $clog2(H_LIMIT) : 1;
    localparam int ADDR_PROD_W = SIZE_W + YW + 1;

    localparam logic [COLOR_W-1:0] COLOR_MASK =
        COLOR_W'((64'd1 << COLOR_BITS) - 64'd1);

    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH   = 4;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        WRAP_REPEAT,
        WRAP_MIRROR,
        WRAP_CLAMP_EDGE,
        WRAP_CLAMP_BORDER
    } tws_wrap_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_WRAP_S,
        CFG_WRAP_T,
        CFG_BORDER
    } tws_cfg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        tws_wrap_t         wrap_s;
        tws_wrap_t         wrap_t;
    } tws_cfg_t;

    typedef struct packed {
        logic                is_write;
        logic                border;
        logic [STORE_AW-1:0] addr;
        logic [COLOR_W-1:0]  color;
    } tws_cmd_t;

    typedef struct packed {
        logic              border;
        logic [SIZE_W-1:0] pos;
    } tws_axis_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] maxv
    );
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // nearest texel on one axis, one 16x7 multiply
    function automatic tws_axis_t map_axis(
        input logic [COORD_W-1:0] c,
        input logic [SIZE_W-1:0]  n,
        input tws_wrap_t          mode
    );
        tws_axis_t                  r;
        logic [FRAC_W-1:0]          frac;
        logic [FRAC_W-1:0]          m;
        logic                       negative;
        logic                       odd;
        logic                       in_range;
        logic                       use_prod;
        logic [FRAC_W+SIZE_W-1:0]   prod;
        frac     = c[FRAC_W-1:0];
        negative = c[COORD_W-1];
        odd      = c[FRAC_W];
        in_range = (c[COORD_W-1:FRAC_W] == '0);
        m        = frac;
        use_prod = 1'b1;
        r.border = 1'b0;
        r.pos    = '0;
        if (!in_range) begin
            case (mode)
                WRAP_REPEAT: begin
                    m = frac;
                end
                WRAP_MIRROR: begin
                    if (odd) begin
                        if (frac == '0) begin
                            // mirrored fraction of exactly one lands on the last texel
                            use_prod = 1'b0;
                            r.pos    = n - SIZE_W'(1);
                        end else begin
                            m = FRAC_W'(17'h10000 - {1'b0, frac});
                        end
                    end
                end
                WRAP_CLAMP_EDGE: begin
                    use_prod = 1'b0;
                    r.pos    = negative ? '0 : n - SIZE_W'(1);
                end
                default: begin
                    use_prod = 1'b0;
                    r.border = 1'b1;
                end
            endcase
        end
        prod = (FRAC_W + SIZE_W)'(m) * (FRAC_W + SIZE_W)'(n);
        if (use_prod)
            r.pos = prod[FRAC_W+SIZE_W-1:FRAC_W];
        return r;
    endfunction

endpackage

[rtl/core/tws_ram.sv]
// generic single write port, single read port ram with registered read
module tws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/tws_front.sv]
// front end: accepts items, maps coordinates and forms texel addresses
module tws_front
    import tws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tws_cfg_t            cfg,
    input  logic                push,
    output logic                full,
    input  logic                func,
    input  logic [INDEX_W-1:0]  texel_index,
    input  logic [COLOR_W-1:0]  texel_color,
    input  logic signed [COORD_W-1:0] coord_s,
    input  logic signed [COORD_W-1:0] coord_t,
    output logic                cmd_valid,
    output tws_cmd_t            cmd,
    input  logic                cmd_ready
);

    logic                f1_valid_reg, f1_valid_next;
    logic                f1_func_reg;
    logic [INDEX_W-1:0]  f1_index_reg;
    logic [COLOR_W-1:0]  f1_color_reg;
    logic [XW-1:0]       f1_x_reg;
    logic [YW-1:0]       f1_y_reg;
    logic                f1_border_reg;

    logic                accept;
    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;
    tws_axis_t           ax_s;
    tws_axis_t           ax_t;
    logic [ADDR_PROD_W-1:0] addr_prod;

    assign w_eff  = clamp_size(cfg.width, SIZE_W'(W_LIMIT));
    assign h_eff  = clamp_size(cfg.height, SIZE_W'(H_LIMIT));
    assign ax_s   = map_axis($unsigned(coord_s), w_eff, cfg.wrap_s);
    assign ax_t   = map_axis($unsigned(coord_t), h_eff, cfg.wrap_t);

    assign full   = f1_valid_reg && !cmd_ready;
    assign accept = push && !full;

    always_comb
    begin
        f1_valid_next = accept || (f1_valid_reg && !cmd_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= f1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_func_reg   <= func;
            f1_index_reg  <= texel_index;
            f1_color_reg  <= texel_color & COLOR_MASK;
            f1_x_reg      <= XW'(ax_s.pos);
            f1_y_reg      <= YW'(ax_t.pos);
            f1_border_reg <= ax_s.border || ax_t.border;
        end
    end

    // linear address width*y+x, wraps modulo the store depth
    assign addr_prod = ADDR_PROD_W'(w_eff) * ADDR_PROD_W'(f1_y_reg) + ADDR_PROD_W'(f1_x_reg);

    always_comb
    begin
        cmd_valid    = f1_valid_reg;
        cmd.is_write = (f1_func_reg == FUNC_WRITE);
        cmd.border   = f1_border_reg;
        cmd.color    = f1_color_reg;
        if (f1_func_reg == FUNC_WRITE)
            cmd.addr = STORE_AW'(f1_index_reg);
        else
            cmd.addr = STORE_AW'(addr_prod);
    end

endmodule

[rtl/core/tws_cmd_queue.sv]
// short command queue between front end and back end
module tws_cmd_queue
    import tws_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  tws_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop_ready,
    output tws_cmd_t pop_cmd
);

    tws_cmd_t               entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0]   count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMD_CNT_W'(CMD_DEPTH))
        else $error("command queue count out of range");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CMD_CNT_W'(1)))
        else $error("command queue lost a push");

endmodule

[rtl/core/tws_back.sv]
// back end: texel store writes and reads, result queue
module tws_back
    import tws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COLOR_W-1:0] border_color,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tws_cmd_t           cmd,
    output logic               empty,
    input  logic               pop,
    output logic [COLOR_W-1:0] sample_color,
    output logic               used_border
);

    logic                 b1_valid_reg, b1_valid_next;
    logic                 b1_border_reg, b1_border_next;

    logic [COLOR_W-1:0]   res_color_reg  [RES_DEPTH];
    logic                 res_border_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_ptr_reg, res_wr_ptr_next;
    logic [RES_PTR_W-1:0] res_rd_ptr_reg, res_rd_ptr_next;
    logic [RES_CNT_W-1:0] res_count_reg, res_count_next;

    logic                 space;
    logic                 take;
    logic                 ram_we;
    logic                 ram_re;
    logic [COLOR_W-1:0]   ram_rdata;
    logic                 res_push;
    logic                 res_pop;
    logic [COLOR_W-1:0]   res_color_in;

    // a sample leaves the queue only when its result has a slot reserved
    assign space     = (RES_CNT_W'(res_count_reg) + RES_CNT_W'(b1_valid_reg))
                       < RES_CNT_W'(RES_DEPTH);
    assign cmd_ready = cmd.is_write || space;
    assign take      = cmd_valid && cmd_ready;
    assign ram_we    = take && cmd.is_write;
    assign ram_re    = take && !cmd.is_write && !cmd.border;

    tws_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_texel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (cmd.color),
        .re    (ram_re),
        .raddr (cmd.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        b1_valid_next  = take && !cmd.is_write;
        b1_border_next = b1_border_reg;
        if (take)
            b1_border_next = cmd.border;
    end

    assign res_push     = b1_valid_reg;
    assign res_pop      = pop && !empty;
    assign res_color_in = b1_border_reg ? (border_color & COLOR_MASK) : ram_rdata;

    always_comb
    begin
        res_wr_ptr_next = res_push ? res_wr_ptr_reg + RES_PTR_W'(1) : res_wr_ptr_reg;
        res_rd_ptr_next = res_pop ? res_rd_ptr_reg + RES_PTR_W'(1) : res_rd_ptr_reg;
        res_count_next  = res_count_reg + RES_CNT_W'(res_push) - RES_CNT_W'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            b1_valid_reg   <= b1_valid_next;
            res_wr_ptr_reg <= res_wr_ptr_next;
            res_rd_ptr_reg <= res_rd_ptr_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_border_reg <= b1_border_next;
        if (res_push)
        begin
            res_color_reg[res_wr_ptr_reg]  <= res_color_in;
            res_border_reg[res_wr_ptr_reg] <= b1_border_reg;
        end
    end

    assign empty        = (res_count_reg == '0);
    assign sample_color = res_color_reg[res_rd_ptr_reg];
    assign used_border  = res_border_reg[res_rd_ptr_reg];

    a_no_overcommit: assert property (@(posedge clk) disable iff (!rst_n)
        (RES_CNT_W'(res_count_reg) + RES_CNT_W'(b1_valid_reg)) <= RES_CNT_W'(RES_DEPTH))
        else $error("result slots overcommitted");

    a_landing_slot: assert property (@(posedge clk) disable iff (!rst_n)
        b1_valid_reg |-> (res_count_reg < RES_CNT_W'(RES_DEPTH)))
        else $error("result landed with no free slot");

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("texel store read and write in one cycle");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (b1_valid_reg && !b1_border_reg))
        else $error("texel read without a result in flight");

endmodule

[rtl/core/texture_wrap_nearest_sampler.sv]
// top level of the nearest texture sampler with wrap modes
// throughput: one transaction per cycle, writes and samples alike, while the result queue has room
// a sample's result passes the front stage, the command queue, the texel store read and the result queue
// before it shows on the result ports; a write passes the front stage and the command queue into the store
// reset: queues and pipeline valids clear, size registers go to 64, wrap modes to repeat,
// border color to zero; the texel store is not cleared and holds garbage until written
module texture_wrap_nearest_sampler
    import tws_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // input queue side
    input  logic                      push,
    output logic                      full,
    input  logic                      func,
    input  logic [INDEX_W-1:0]        texel_index,
    input  logic [COLOR_W-1:0]        texel_color,
    input  logic signed [COORD_W-1:0] coord_s,
    input  logic signed [COORD_W-1:0] coord_t,

    // result queue side
    output logic                      empty,
    input  logic                      pop,
    output logic [COLOR_W-1:0]        sample_color,
    output logic                      used_border,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [SIZE_W-1:0]  width_reg, width_next;
    logic [SIZE_W-1:0]  height_reg, height_next;
    tws_wrap_t          wrap_s_reg, wrap_s_next;
    tws_wrap_t          wrap_t_reg, wrap_t_next;
    logic [COLOR_W-1:0] border_reg, border_next;

    tws_cfg_t           cfg;
    logic               cfg_write;

    // front to queue and queue to back
    logic               f_cmd_valid;
    logic               f_cmd_ready;
    tws_cmd_t           f_cmd;
    logic               b_cmd_valid;
    logic               b_cmd_ready;
    tws_cmd_t           b_cmd;

    // configuration is always accepted; user must see it written only while the block is idle; not checked
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        wrap_s_next = wrap_s_reg;
        wrap_t_next = wrap_t_reg;
        border_next = border_reg;
        if (cfg_write)
        begin
            case (tws_cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_next  = cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_next = cfg_data[SIZE_W-1:0];
                CFG_WRAP_S: wrap_s_next = tws_wrap_t'(cfg_data[1:0]);
                CFG_WRAP_T: wrap_t_next = tws_wrap_t'(cfg_data[1:0]);
                CFG_BORDER: border_next = cfg_data[COLOR_W-1:0];
                default:    ; // unmapped index, transaction dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(64);
            height_reg <= SIZE_W'(64);
            wrap_s_reg <= WRAP_REPEAT;
            wrap_t_reg <= WRAP_REPEAT;
            border_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            wrap_s_reg <= wrap_s_next;
            wrap_t_reg <= wrap_t_next;
            border_reg <= border_next;
        end
    end

    always_comb
    begin
        cfg.width  = width_reg;
        cfg.height = height_reg;
        cfg.wrap_s = wrap_s_reg;
        cfg.wrap_t = wrap_t_reg;
    end

    // front: accepts transactions, maps both axes, builds the texel address
    tws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .full        (full),
        .func        (func),
        .texel_index (texel_index),
        .texel_color (texel_color),
        .coord_s     (coord_s),
        .coord_t     (coord_t),
        .cmd_valid   (f_cmd_valid),
        .cmd         (f_cmd),
        .cmd_ready   (f_cmd_ready)
    );

    // decoupling queue so front and back stall independently
    tws_cmd_queue u_cmd_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_cmd_valid),
        .push_ready (f_cmd_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (b_cmd_valid),
        .pop_ready  (b_cmd_ready),
        .pop_cmd    (b_cmd)
    );

    // back: texel store access, border select, result queue
    tws_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .border_color (border_reg),
        .cmd_valid    (b_cmd_valid),
        .cmd_ready    (b_cmd_ready),
        .cmd          (b_cmd),
        .empty        (empty),
        .pop          (pop),
        .sample_color (sample_color),
        .used_border  (used_border)
    );

endmodule

[dv/texel_sample_checker.sv]
// checker for the texture sampler: mirrors texel store and registers, predicts each sample
`timescale 1ns / 1ps

module texel_sample_checker
    import tws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  func,
    input  logic [INDEX_W-1:0]    texel_index,
    input  logic [COLOR_W-1:0]    texel_color,
    input  logic [COORD_W-1:0]    coord_s,
    input  logic [COORD_W-1:0]    coord_t,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [COLOR_W-1:0]    sample_color,
    input  logic                  used_border,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               border;
    } sample_t;

    logic [COLOR_W-1:0] texels [STORE_DEPTH];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    tws_wrap_t          wrap_s_reg;
    tws_wrap_t          wrap_t_reg;
    logic [COLOR_W-1:0] border_reg;
    sample_t            expected_samples [$];
    sample_t            want;
    int                 mismatch_count = 0;

    assign mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned span(input logic [SIZE_W-1:0] raw, input int unsigned maxv);
        if (raw == '0)
            return 1;
        if (raw > maxv)
            return maxv;
        return {{(32 - SIZE_W){1'b0}}, raw};
    endfunction

    // texel position on one axis, n means the axis fell on the border
    function automatic int unsigned axis_texel(
        input logic [COORD_W-1:0] c,
        input int unsigned        n,
        input tws_wrap_t          mode
    );
        int unsigned f;
        f = {{(32 - FRAC_W){1'b0}}, c[FRAC_W-1:0]};
        if (c[COORD_W-1:FRAC_W] == '0)
            return (f * n) >> FRAC_W;
        case (mode)
            WRAP_REPEAT:
                return (f * n) >> FRAC_W;
            WRAP_MIRROR: begin
                if (!c[FRAC_W])
                    return (f * n) >> FRAC_W;
                if (f == 0)
                    return n - 1;
                return (((1 << FRAC_W) - f) * n) >> FRAC_W;
            end
            WRAP_CLAMP_EDGE:
                return c[COORD_W-1] ? 0 : n - 1;
            default:
                return n;
        endcase
    endfunction

    function automatic sample_t predict_sample(
        input logic [COORD_W-1:0] s,
        input logic [COORD_W-1:0] t
    );
        sample_t     r;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = span(width_reg, MAX_WIDTH);
        h = span(height_reg, MAX_HEIGHT);
        x = axis_texel(s, w, wrap_s_reg);
        y = axis_texel(t, h, wrap_t_reg);
        if (x == w || y == h) begin
            r.color  = border_reg & COLOR_MASK;
            r.border = 1'b1;
        end else begin
            r.color  = texels[(w * y + x) & (STORE_DEPTH - 1)] & COLOR_MASK;
            r.border = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  = SIZE_W'(64);
            height_reg = SIZE_W'(64);
            wrap_s_reg = WRAP_REPEAT;
            wrap_t_reg = WRAP_REPEAT;
            border_reg = '0;
            expected_samples.delete();
            pending <= 0;
        end else begin
            // result side first: a result can never belong to an item entering this edge
            if (pop && !empty) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected result color %06h border %0b",
                                              sample_color, used_border));
                end else begin
                    want = expected_samples.pop_front();
                    if (sample_color !== want.color)
                        report_mismatch($sformatf("sample_color %06h, expected %06h",
                                                  sample_color, want.color));
                    if (used_border !== want.border)
                        report_mismatch($sformatf("used_border %0b, expected %0b",
                                                  used_border, want.border));
                end
            end
            if (push && !full) begin
                if (func == FUNC_WRITE)
                    texels[texel_index] = texel_color & COLOR_MASK;
                else
                    expected_samples.push_back(predict_sample(coord_s, coord_t));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  = cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
                    CFG_WRAP_S: wrap_s_reg = tws_wrap_t'(cfg_data[1:0]);
                    CFG_WRAP_T: wrap_t_reg = tws_wrap_t'(cfg_data[1:0]);
                    CFG_BORDER: border_reg = cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            pending <= expected_samples.size();
        end
    end

endmodule

[dv/testbench.sv]
// top of the sampler testbench: clock, reset, stimulus, result drain and verdict
`timescale 1ns / 1ps

module testbench;
    import tws_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int ITEM_TARGET    = 1650;
    // wait after the last result so that an in-flight write has landed in the store
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 10;
    // long receiver hold, well past what the command and result queues can absorb
    localparam int LONG_HOLD      = 150;
    // quiet cycles allowed; longest legal quiet stretch is the long hold
    localparam int WATCHDOG_LIMIT = 2000;
    // cap on texels a random setting may address, keeps the store fill cheap
    localparam int AREA_CAP       = 512;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_BORDER + 1);
    localparam logic [CFG_DATA_W-1:0] SIZE_FIELD  = 24'h00007F;
    localparam logic [CFG_DATA_W-1:0] WRAP_FIELD  = 24'h000003;
    localparam logic [CFG_DATA_W-1:0] COLOR_FIELD = 24'hFFFFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  func = FUNC_WRITE;
    logic [INDEX_W-1:0]    texel_index = '0;
    logic [COLOR_W-1:0]    texel_color = '0;
    logic [COORD_W-1:0]    coord_s = '0;
    logic [COORD_W-1:0]    coord_t = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [COLOR_W-1:0]    sample_color;
    logic                  used_border;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int items_sent = 0;
    int quiet_cycles = 0;
    // long-hold requests from the stimulus, served by the result drain
    int hold_requests = 0;
    int holds_served = 0;
    bit steady_push = 1'b0;
    // texels written so far; samples only ever reach written ones
    bit written [STORE_DEPTH];

    always #(CLK_PERIOD / 2) clk = ~clk;

    texture_wrap_nearest_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .texel_index  (texel_index),
        .texel_color  (texel_color),
        .coord_s      (coord_s),
        .coord_t      (coord_t),
        .empty        (empty),
        .pop          (pop),
        .sample_color (sample_color),
        .used_border  (used_border),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    texel_sample_checker sample_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .texel_index  (texel_index),
        .texel_color  (texel_color),
        .coord_s      (coord_s),
        .coord_t      (coord_t),
        .empty        (empty),
        .pop          (pop),
        .sample_color (sample_color),
        .used_border  (used_border),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // effective texels on an axis: zero reads as one, oversize saturates
    function automatic int unsigned span(input int unsigned raw, input int unsigned maxv);
        if (raw == 0)
            return 1;
        if (raw > maxv)
            return maxv;
        return raw;
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 64;
            3:       return $urandom_range(65, 127);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // coordinates biased toward the corners of the wrap logic
    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] c;
        c = COORD_W'($urandom());
        case ($urandom_range(0, 5))
            0: c[COORD_W-1:FRAC_W] = '0;              // in range
            1: c[FRAC_W-1:0] = '0;                    // whole number, mirrored one on odd
            2: c[FRAC_W-1:0] = '1;                    // just below the next integer
            3: ;                                      // anything
            4: begin                                  // close to zero on either side
                if ($urandom_range(0, 1) != 0)
                    c[COORD_W-1:FRAC_W] = (COORD_W - FRAC_W)'($urandom_range(0, 3));
                else
                    c[COORD_W-1:FRAC_W] = (COORD_W - FRAC_W)'(-$urandom_range(1, 3));
            end
            default: begin                            // range extremes
                case ($urandom_range(0, 3))
                    0:       c = 24'h7FFFFF;
                    1:       c = 24'h800000;
                    2:       c = 24'hFFFFFF;
                    default: c = 24'h010000;
                endcase
            end
        endcase
        return c;
    endfunction

    // offer one item after an optional gap and hold it until the block takes it;
    // valid stays high into the next item when there is no gap
    task automatic send_item(
        input logic               f,
        input logic [INDEX_W-1:0] idx,
        input logic [COLOR_W-1:0] color,
        input logic [COORD_W-1:0] s,
        input logic [COORD_W-1:0] t
    );
        int gap;
        gap = pick_gap(steady_push);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        func        <= f;
        texel_index <= idx;
        texel_color <= color;
        coord_s     <= s;
        coord_t     <= t;
        @(posedge clk);
        while (full) @(posedge clk);
        if (f == FUNC_WRITE)
            written[idx] = 1'b1;
        items_sent++;
    endtask

    task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [COLOR_W-1:0] color);
        send_item(FUNC_WRITE, idx, color, rand_coord(), rand_coord());
    endtask

    task automatic send_sample(input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] t);
        send_item(FUNC_SAMPLE, INDEX_W'($urandom()), COLOR_W'($urandom()), s, t);
    endtask

    // stop offering, wait for every sample result, then let a trailing write land
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register transaction; bits outside the field carry random junk
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] value,
        input logic [CFG_DATA_W-1:0] field
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (value & field) | (CFG_DATA_W'($urandom()) & ~field);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic configure(
        input int unsigned        w_raw,
        input int unsigned        h_raw,
        input tws_wrap_t          mode_s,
        input tws_wrap_t          mode_t,
        input logic [COLOR_W-1:0] border
    );
        write_reg(CFG_WIDTH, CFG_DATA_W'(w_raw), SIZE_FIELD);
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h_raw), SIZE_FIELD);
        write_reg(CFG_WRAP_S, CFG_DATA_W'(mode_s), WRAP_FIELD);
        write_reg(CFG_WRAP_T, CFG_DATA_W'(mode_t), WRAP_FIELD);
        write_reg(CFG_BORDER, border, COLOR_FIELD);
        cfg_valid <= 1'b0;
    endtask

    // main stimulus
    initial begin : stimulus
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned area;
        int          phase;
        int          body_len;
        logic [COLOR_W-1:0] border;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset setting: 64x64, repeat on both axes, black border.
        // only the four corner texels are written and every sample lands on one
        send_write(12'd0, 24'hFFFFFF);
        send_write(12'd63, 24'h000000);
        send_write(12'd4032, COLOR_W'($urandom()));
        send_write(12'd4095, COLOR_W'($urandom()));
        send_sample(24'h000000, 24'h000000);   // origin
        send_sample(24'h00FFFF, 24'h000000);   // last column
        send_sample(24'h000000, 24'h00FFFF);   // last row
        send_sample(24'h7FFFFF, 24'h800000);   // most positive s, most negative t
        send_sample(24'hFFFFFF, 24'hFFFFFF);   // just below zero wraps to the far corner
        send_sample(24'h010000, 24'hFF0000);   // whole numbers repeat to texel zero
        settle();

        // unused register indexes must be harmless
        for (int i = CFG_SPARE; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom()), '0);
        cfg_valid <= 1'b0;

        // oversize width saturates to 64, zero height reads as one;
        // mirrored s with clamp-to-edge t
        configure(127, 0, WRAP_MIRROR, WRAP_CLAMP_EDGE, 24'h000000);
        send_sample(24'h010000, rand_coord());  // mirrored fraction of exactly one
        send_sample(24'hFF0000, 24'hFF8000);    // negative odd integer, negative t
        send_sample(24'h01FFFF, 24'h7F0000);    // odd, fraction nearly one mirrors to 0
        send_sample(24'h02FFFF, 24'h000123);    // even integer keeps the fraction
        settle();

        // zero width, full height; s on border clamp, t clamps to edge
        configure(0, 64, WRAP_CLAMP_BORDER, WRAP_CLAMP_EDGE, 24'hFFFFFF);
        send_sample(24'h0000FF, 24'h7FFFFF);    // t clamps to the last row
        send_sample(24'h00ABCD, 24'h800000);    // t clamps to row zero
        send_sample(24'h010000, 24'h000000);    // s out of range lands on the border
        send_sample(24'h800000, 24'h000000);
        settle();

        // random settings; every phase is entered idle
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            w_raw = pick_size();
            h_raw = pick_size();
            if (span(w_raw, MAX_WIDTH) * span(h_raw, MAX_HEIGHT) > AREA_CAP)
                h_raw = $urandom_range(1, AREA_CAP / span(w_raw, MAX_WIDTH));
            area = span(w_raw, MAX_WIDTH) * span(h_raw, MAX_HEIGHT);
            case ($urandom_range(0, 4))
                0:       border = '0;
                1:       border = '1;
                default: border = COLOR_W'($urandom());
            endcase
            configure(w_raw, h_raw, tws_wrap_t'($urandom_range(0, 3)),
                      tws_wrap_t'($urandom_range(0, 3)), border);

            // make every reachable texel defined before sampling
            steady_push = ($urandom_range(0, 3) == 0);
            for (int a = 0; a < area; a++)
                if (!written[a])
                    send_write(INDEX_W'(a), COLOR_W'($urandom()));

            // in two phases the items go back to back while the result side holds off
            if (phase == 1 || phase == 7) begin
                hold_requests++;
                steady_push = 1'b1;
            end

            body_len = $urandom_range(40, 120);
            for (int k = 0; k < body_len; k++) begin
                if ($urandom_range(0, 9) < 7)
                    send_sample(rand_coord(), rand_coord());
                else if ($urandom_range(0, 4) != 0)
                    send_write(INDEX_W'($urandom_range(0, area - 1)), COLOR_W'($urandom()));
                else
                    send_write(INDEX_W'($urandom()), COLOR_W'($urandom()));
            end
            settle();
            phase++;
        end

        // everything offered; wait out the last results and a quiet tail
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result drain: random pop gaps, steady stretches, and the long holds on request
    initial begin : result_drain
        int idle_left;
        int mode_left;
        bit steady;
        idle_left = 0;
        mode_left = 0;
        steady    = 1'b0;
        @(posedge clk);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served++;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(50, 300);
                end else begin
                    mode_left--;
                end
                if (idle_left > 0) begin
                    pop <= 1'b0;
                    idle_left--;
                end else begin
                    pop <= 1'b1;
                    idle_left = pick_gap(steady);
                end
                @(posedge clk);
            end
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/core/tws_pkg.sv
rtl/core/tws_ram.sv
rtl/core/tws_front.sv
rtl/core/tws_cmd_queue.sv
rtl/core/tws_back.sv
rtl/core/texture_wrap_nearest_sampler.sv
dv/texel_sample_checker.sv
dv/testbench.sv
